// ----- design/pressure_temperature_compensation_unit_defines.svh -----
// assertion macros for the pressure and temperature compensation unit
`ifndef PRESSURE_TEMPERATURE_COMPENSATION_UNIT_DEFINES_SVH
`define PRESSURE_TEMPERATURE_COMPENSATION_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define PTC_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define PTC_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/ptc_pkg.sv -----
// shared types, register codes and arithmetic helpers for the compensation unit
`default_nettype none
package ptc_pkg;

    localparam int unsigned WORD_W     = 32;
    localparam int unsigned DIV_STAGES = WORD_W;
    localparam int unsigned RAW_W      = 20;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [RAW_W-1:0]  raw_t;

    typedef enum logic [1:0] {
        REG_TEMP_TRIM = 2'd0,
        REG_PRESS_A   = 2'd1,
        REG_PRESS_B   = 2'd2,
        REG_PRESS_C   = 2'd3
    } reg_idx_t;

    // trim words, already extended to 32 bits
    typedef struct packed {
        word_t t1;
        word_t t2;
        word_t t3;
        word_t p1;
        word_t p2;
        word_t p3;
        word_t p4;
        word_t p5;
        word_t p6;
        word_t p7;
        word_t p8;
        word_t p9;
    } trim_t;

    typedef struct packed {
        word_t temp;
        word_t fine;
    } side_t;

    typedef struct packed {
        word_t dividend;
        word_t divisor;
        logic  dbl;
        logic  dz;
        side_t side;
    } div_in_t;

    typedef struct packed {
        word_t quot;
        logic  dbl;
        logic  dz;
        side_t side;
    } div_out_t;

    typedef struct packed {
        side_t side;
        word_t pressure;
        logic  dz;
    } result_t;

    function automatic word_t asr(input word_t x, input logic [4:0] n);
        return word_t'($signed(x) >>> n);
    endfunction

    function automatic word_t sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic word_t ux16(input logic [15:0] v);
        return {16'd0, v};
    endfunction

endpackage
`default_nettype wire

// ----- design/ptc_temp.sv -----
// temperature polynomial: three stages from raw reading to fine temperature
`default_nettype none
module ptc_temp (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 en,
    input  wire                 in_valid,
    input  ptc_pkg::raw_t       adc_t,
    input  ptc_pkg::raw_t       adc_p,
    input  ptc_pkg::trim_t      trim,
    output logic                out_valid,
    output ptc_pkg::word_t      out_fine,
    output ptc_pkg::raw_t       out_adc_p
);

    logic           v1_reg, v2_reg, v3_reg;
    ptc_pkg::word_t m1_reg, m1_next, m2_reg, m2_next;
    ptc_pkg::word_t a_reg, a_next, m3_reg, m3_next;
    ptc_pkg::word_t fine_reg, fine_next;
    ptc_pkg::raw_t  p1_reg, p2_reg, p3_reg;
    ptc_pkg::word_t x1, d, dd;

    always_comb begin
        x1      = {15'd0, adc_t[19:3]} - {trim.t1[30:0], 1'b0};
        d       = {16'd0, adc_t[19:4]} - trim.t1;
        m1_next = x1 * trim.t2;
        m2_next = d * d;
        a_next  = ptc_pkg::asr(m1_reg, 5'd11);
        dd      = ptc_pkg::asr(m2_reg, 5'd12);
        m3_next = dd * trim.t3;
        fine_next = a_reg + ptc_pkg::asr(m3_reg, 5'd14);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m1_reg   <= m1_next;
            m2_reg   <= m2_next;
            p1_reg   <= adc_p;
            a_reg    <= a_next;
            m3_reg   <= m3_next;
            p2_reg   <= p1_reg;
            fine_reg <= fine_next;
            p3_reg   <= p2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out_fine  = fine_reg;
    assign out_adc_p = p3_reg;

endmodule
`default_nettype wire

// ----- design/ptc_press.sv -----
// pressure polynomial: five stages from fine temperature to divider operands
`default_nettype none
module ptc_press (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 en,
    input  wire                 in_valid,
    input  ptc_pkg::word_t      fine,
    input  ptc_pkg::raw_t       adc_p,
    input  ptc_pkg::trim_t      trim,
    output logic                out_valid,
    output ptc_pkg::div_in_t    out_data
);

    logic           v_reg [5];
    ptc_pkg::side_t s1_reg, s2_reg, s3_reg, s4_reg, s5_reg;
    ptc_pkg::raw_t  ap1_reg, ap2_reg, ap3_reg;
    ptc_pkg::word_t sq_reg, mp5_reg, mp2_reg;
    ptc_pkg::word_t b1_reg, m3_reg, mp5b_reg, mp2b_reg;
    ptc_pkg::word_t bs_reg, t_reg;
    ptc_pkg::word_t ap_reg, num_reg;
    ptc_pkg::word_t dsr_reg, pn_reg;

    ptc_pkg::side_t s1_next;
    ptc_pkg::word_t pa, q, sq_next, mp5_next, mp2_next, f5;
    ptc_pkg::word_t b1_next, m3_next;
    ptc_pkg::word_t bs_next, t_next;
    ptc_pkg::word_t ap_next, num_next;
    ptc_pkg::word_t dsr_next, pn_next;

    always_comb begin
        // stage 1
        f5           = fine * 32'd5;
        s1_next.fine = fine;
        s1_next.temp = ptc_pkg::asr(f5 + 32'd128, 5'd8);
        pa           = ptc_pkg::asr(fine, 5'd1) - 32'd64000;
        q            = ptc_pkg::asr(pa, 5'd2);
        sq_next      = q * q;
        mp5_next     = pa * trim.p5;
        mp2_next     = trim.p2 * pa;
        // stage 2
        b1_next = ptc_pkg::asr(sq_reg, 5'd11) * trim.p6;
        m3_next = trim.p3 * ptc_pkg::asr(sq_reg, 5'd13);
        // stage 3
        bs_next = ptc_pkg::asr(b1_reg + {mp5b_reg[30:0], 1'b0}, 5'd2)
                + {trim.p4[15:0], 16'd0};
        t_next  = 32'd32768 + ptc_pkg::asr(ptc_pkg::asr(m3_reg, 5'd3)
                + ptc_pkg::asr(mp2b_reg, 5'd1), 5'd18);
        // stage 4
        ap_next  = t_reg * trim.p1;
        num_next = (32'd1048576 - {12'd0, ap3_reg}) - ptc_pkg::asr(bs_reg, 5'd12);
        // stage 5
        dsr_next = ptc_pkg::asr(ap_reg, 5'd15);
        pn_next  = num_reg * 32'd3125;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 5; i++) v_reg[i] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= in_valid;
            for (int i = 1; i < 5; i++) v_reg[i] <= v_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_reg   <= s1_next;
            ap1_reg  <= adc_p;
            sq_reg   <= sq_next;
            mp5_reg  <= mp5_next;
            mp2_reg  <= mp2_next;
            s2_reg   <= s1_reg;
            ap2_reg  <= ap1_reg;
            b1_reg   <= b1_next;
            m3_reg   <= m3_next;
            mp5b_reg <= mp5_reg;
            mp2b_reg <= mp2_reg;
            s3_reg   <= s2_reg;
            ap3_reg  <= ap2_reg;
            bs_reg   <= bs_next;
            t_reg    <= t_next;
            s4_reg   <= s3_reg;
            ap_reg   <= ap_next;
            num_reg  <= num_next;
            s5_reg   <= s4_reg;
            dsr_reg  <= dsr_next;
            pn_reg   <= pn_next;
        end
    end

    // below 2^31 the numerator is doubled before the divide, else the quotient is
    always_comb begin
        out_data.divisor  = dsr_reg;
        out_data.dz       = (dsr_reg == '0);
        out_data.dbl      = pn_reg[31];
        out_data.dividend = pn_reg[31] ? pn_reg : {pn_reg[30:0], 1'b0};
        out_data.side     = s5_reg;
    end

    assign out_valid = v_reg[4];

endmodule
`default_nettype wire

// ----- design/ptc_div.sv -----
// pipelined restoring divider, one quotient bit per stage
`default_nettype none
module ptc_div (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 en,
    input  wire                 in_valid,
    input  ptc_pkg::div_in_t    in_data,
    output logic                out_valid,
    output ptc_pkg::div_out_t   out_data
);

    localparam int unsigned N = ptc_pkg::DIV_STAGES;
    localparam int unsigned W = ptc_pkg::WORD_W;

    typedef struct packed {
        ptc_pkg::word_t rem;
        ptc_pkg::word_t dvd;
        ptc_pkg::word_t dsr;
        ptc_pkg::word_t quo;
        logic           dbl;
        logic           dz;
        ptc_pkg::side_t side;
    } stg_t;

    logic v_reg   [1:N];
    stg_t stg_reg [1:N];
    stg_t stg_first;

    always_comb begin
        stg_first.rem  = '0;
        stg_first.dvd  = in_data.dividend;
        stg_first.dsr  = in_data.divisor;
        stg_first.quo  = '0;
        stg_first.dbl  = in_data.dbl;
        stg_first.dz   = in_data.dz;
        stg_first.side = in_data.side;
    end

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic       cur_v;
        stg_t       cur;
        logic [W:0] trial;
        logic [W:0] diff;
        stg_t       stg_next;

        if (k == 0) begin : g_head
            assign cur_v = in_valid;
            assign cur   = stg_first;
        end else begin : g_body
            assign cur_v = v_reg[k];
            assign cur   = stg_reg[k];
        end

        always_comb begin
            trial    = {cur.rem, cur.dvd[W-1]};
            diff     = trial - {1'b0, cur.dsr};
            stg_next = cur;
            stg_next.dvd = {cur.dvd[W-2:0], 1'b0};
            stg_next.rem = diff[W] ? trial[W-1:0] : diff[W-1:0];
            stg_next.quo = {cur.quo[W-2:0], ~diff[W]};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k+1] <= 1'b0;
            end else if (en) begin
                v_reg[k+1] <= cur_v;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                stg_reg[k+1] <= stg_next;
            end
        end
    end

    assign out_valid     = v_reg[N];
    assign out_data.quot = stg_reg[N].quo;
    assign out_data.dbl  = stg_reg[N].dbl;
    assign out_data.dz   = stg_reg[N].dz;
    assign out_data.side = stg_reg[N].side;

endmodule
`default_nettype wire

// ----- design/ptc_post.sv -----
// pressure correction after the divide: four stages
`default_nettype none
module ptc_post (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 en,
    input  wire                 in_valid,
    input  ptc_pkg::div_out_t   in_data,
    input  ptc_pkg::trim_t      trim,
    output logic                out_valid,
    output ptc_pkg::result_t    out_data
);

    logic           v_reg [4];
    ptc_pkg::side_t s1_reg, s2_reg, s3_reg;
    logic           dz1_reg, dz2_reg, dz3_reg;
    ptc_pkg::word_t p1_reg, p2_reg, p3_reg;
    ptc_pkg::word_t qq_reg, mb_reg, a_reg, b_reg;
    ptc_pkg::result_t res_reg, res_next;

    ptc_pkg::word_t p1_next, ps3, sqp, qq_next, mb_next, pr9, a_next, b_next;

    always_comb begin
        p1_next = in_data.dbl ? {in_data.quot[30:0], 1'b0} : in_data.quot;
        ps3     = {3'd0, p1_reg[31:3]};
        sqp     = ps3 * ps3;
        qq_next = {13'd0, sqp[31:13]};
        mb_next = {2'd0, p1_reg[31:2]} * trim.p8;
        pr9     = trim.p9 * qq_reg;
        a_next  = ptc_pkg::asr(pr9, 5'd12);
        b_next  = ptc_pkg::asr(mb_reg, 5'd13);
        res_next.side     = s3_reg;
        res_next.dz       = dz3_reg;
        res_next.pressure = dz3_reg ? '0
                          : p3_reg + ptc_pkg::asr(a_reg + b_reg + trim.p7, 5'd4);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) v_reg[i] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= in_valid;
            for (int i = 1; i < 4; i++) v_reg[i] <= v_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_reg  <= in_data.side;
            dz1_reg <= in_data.dz;
            p1_reg  <= p1_next;
            s2_reg  <= s1_reg;
            dz2_reg <= dz1_reg;
            p2_reg  <= p1_reg;
            qq_reg  <= qq_next;
            mb_reg  <= mb_next;
            s3_reg  <= s2_reg;
            dz3_reg <= dz2_reg;
            p3_reg  <= p2_reg;
            a_reg   <= a_next;
            b_reg   <= b_next;
            res_reg <= res_next;
        end
    end

    assign out_valid = v_reg[3];
    assign out_data  = res_reg;

endmodule
`default_nettype wire

// ----- design/pressure_temperature_compensation_unit.sv -----
// path: from input transaction to result through the 3 temperature, 5 pressure,
// 32 divider and 4 correction stages and the output register
// throughput: one transaction per cycle while the skid buffer is empty; one quotient bit per divider stage
// the whole pipeline holds while its one-entry skid buffer is occupied
// reset: synchronous active-low aresetn clears valid bits and trim registers to 0
// trim registers are to be written over apb only while the pipeline is empty; the block does not enforce it
`default_nettype none
`include "pressure_temperature_compensation_unit_defines.svh"
module pressure_temperature_compensation_unit (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_tvalid,
    output logic         s_tready,
    // [19:0] raw_temperature, [39:20] raw_pressure
    input  wire  [39:0]  s_tdata,
    output logic         m_tvalid,
    input  wire          m_tready,
    // [31:0] temperature_centi, [63:32] fine_temperature, [95:64] pressure_pa
    output logic [95:0]  m_tdata,
    // [0] divide_by_zero
    output logic         m_tuser,
    input  wire          psel,
    input  wire          penable,
    input  wire          pwrite,
    input  wire  [4:0]   paddr,
    input  wire  [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);

    logic [47:0] temp_trim_reg;
    logic [63:0] press_a_reg, press_b_reg;
    logic [15:0] press_c_reg;
    ptc_pkg::reg_idx_t idx;
    ptc_pkg::trim_t    trim;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign idx    = ptc_pkg::reg_idx_t'(paddr[4:3]);
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_trim_reg <= '0;
            press_a_reg   <= '0;
            press_b_reg   <= '0;
            press_c_reg   <= '0;
        end else if (cfg_wr) begin
            unique case (idx)
                ptc_pkg::REG_TEMP_TRIM: temp_trim_reg <= pwdata[47:0];
                ptc_pkg::REG_PRESS_A:   press_a_reg   <= pwdata;
                ptc_pkg::REG_PRESS_B:   press_b_reg   <= pwdata;
                ptc_pkg::REG_PRESS_C:   press_c_reg   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            ptc_pkg::REG_TEMP_TRIM: prdata = {16'd0, temp_trim_reg};
            ptc_pkg::REG_PRESS_A:   prdata = press_a_reg;
            ptc_pkg::REG_PRESS_B:   prdata = press_b_reg;
            ptc_pkg::REG_PRESS_C:   prdata = {48'd0, press_c_reg};
            default:                prdata = '0;
        endcase
    end

    always_comb begin
        trim.t1 = ptc_pkg::ux16(temp_trim_reg[15:0]);
        trim.t2 = ptc_pkg::sx16(temp_trim_reg[31:16]);
        trim.t3 = ptc_pkg::sx16(temp_trim_reg[47:32]);
        trim.p1 = ptc_pkg::ux16(press_a_reg[15:0]);
        trim.p2 = ptc_pkg::sx16(press_a_reg[31:16]);
        trim.p3 = ptc_pkg::sx16(press_a_reg[47:32]);
        trim.p4 = ptc_pkg::sx16(press_a_reg[63:48]);
        trim.p5 = ptc_pkg::sx16(press_b_reg[15:0]);
        trim.p6 = ptc_pkg::sx16(press_b_reg[31:16]);
        trim.p7 = ptc_pkg::sx16(press_b_reg[47:32]);
        trim.p8 = ptc_pkg::sx16(press_b_reg[63:48]);
        trim.p9 = ptc_pkg::sx16(press_c_reg);
    end

    // pipeline advances whenever the skid buffer is empty
    logic               en;
    logic               t_valid, p_valid, d_valid, r_valid;
    ptc_pkg::word_t     t_fine;
    ptc_pkg::raw_t      t_adc_p;
    ptc_pkg::div_in_t   p_data;
    ptc_pkg::div_out_t  d_data;
    ptc_pkg::result_t   r_data;

    logic               out_valid_reg, skid_valid_reg;
    ptc_pkg::result_t   out_data_reg, skid_data_reg;

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    ptc_temp u_temp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid && s_tready),
        .adc_t     (s_tdata[19:0]),
        .adc_p     (s_tdata[39:20]),
        .trim      (trim),
        .out_valid (t_valid),
        .out_fine  (t_fine),
        .out_adc_p (t_adc_p)
    );

    ptc_press u_press (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (t_valid),
        .fine      (t_fine),
        .adc_p     (t_adc_p),
        .trim      (trim),
        .out_valid (p_valid),
        .out_data  (p_data)
    );

    ptc_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (p_valid),
        .in_data   (p_data),
        .out_valid (d_valid),
        .out_data  (d_data)
    );

    ptc_post u_post (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (d_valid),
        .in_data   (d_data),
        .trim      (trim),
        .out_valid (r_valid),
        .out_data  (r_data)
    );

    logic out_free, pipe_out;
    assign out_free = !out_valid_reg || m_tready;
    assign pipe_out = r_valid && en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= pipe_out;
            end
        end else if (pipe_out) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : r_data;
        end
        if (!out_free && pipe_out) begin
            skid_data_reg <= r_data;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_data_reg.pressure, out_data_reg.side.fine, out_data_reg.side.temp};
    assign m_tuser  = out_data_reg.dz;

    `PTC_ASSERT_IMP(a_skid_needs_out, aclk, aresetn, skid_valid_reg, out_valid_reg, "skid holds a transaction while output is empty")
    `PTC_ASSERT_IMP(a_dz_zero_press, aclk, aresetn, m_tvalid && m_tuser, m_tdata[95:64] == 32'd0, "zero divisor with nonzero pressure")
    `PTC_ASSERT_IMP(a_skid_fill, aclk, aresetn, $rose(skid_valid_reg), $past(out_valid_reg && !m_tready), "skid filled without an output stall")
    `PTC_ASSERT_NXT(a_skid_drain, aclk, aresetn, skid_valid_reg && m_tready, out_valid_reg && !skid_valid_reg, "skid did not drain into output")

endmodule
`default_nettype wire
